### rtl/core/mce_pkg.sv
// ----------------------------------------------------------------------------
// mce_pkg
// Shared types, constants and the restoring divide step for the MBR CHS
// entry encoder.
// ----------------------------------------------------------------------------
package mce_pkg;

  localparam int LBA_W        = 32;
  localparam int DIV_W        = 8;
  localparam int SPT_W        = 6;
  localparam int HPC_W        = 8;
  localparam int CYLCNT_W     = 16;
  localparam int CYL_W        = 10;
  localparam int MAX_CYLINDER = 1023;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_SPT    = 2'd0;
  localparam logic [1:0] REG_HPC    = 2'd1;
  localparam logic [1:0] REG_CYLCNT = 2'd2;

  localparam logic [SPT_W-1:0]    SPT_RST    = 6'd63;
  localparam logic [HPC_W-1:0]    HPC_RST    = 8'd255;
  localparam logic [CYLCNT_W-1:0] CYLCNT_RST = 16'd0;

  // one division in flight: partial remainder and the dividend/quotient word
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [LBA_W-1:0] work;
  } div_lane_t;

  typedef struct packed {
    logic [LBA_W-1:0] lba;
    logic [LBA_W-1:0] size;
    logic [SPT_W-1:0] s_sec;
    logic [SPT_W-1:0] e_sec;
  } side_t;

  typedef struct packed {
    div_lane_t s;
    div_lane_t e;
    side_t     side;
  } cell_data_t;

  typedef struct packed {
    logic [7:0] hb;
    logic [7:0] sb;
    logic [7:0] cb;
  } chs_t;

  // one restoring step: shift in the next dividend bit, set the new quotient bit
  function automatic div_lane_t div_step(div_lane_t l, logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    logic [DIV_W:0] diff;
    div_lane_t      r;
    t      = {l.rem, l.work[LBA_W-1]};
    diff   = t - {1'b0, d};
    r.work = {l.work[LBA_W-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem     = diff[DIV_W-1:0];
      r.work[0] = 1'b1;
    end else begin
      r.rem = t[DIV_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/mce_div_cell.sv
// ----------------------------------------------------------------------------
// mce_div_cell
// One stage of the divider chain: one quotient bit for the start and the end
// lane, with the side data carried along.
// ----------------------------------------------------------------------------
module mce_div_cell
  import mce_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [DIV_W-1:0] divisor,
  input  logic             vld_in,
  input  cell_data_t       data_in,
  output logic             vld_out,
  output cell_data_t       data_out
);

  logic       vld_r;
  cell_data_t data_r;
  cell_data_t data_nxt;

  always_comb begin
    data_nxt      = data_in;
    data_nxt.s    = div_step(data_in.s, divisor);
    data_nxt.e    = div_step(data_in.e, divisor);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign data_out = data_r;

endmodule

### rtl/core/mbr_chs_entry_encoder.sv
// ----------------------------------------------------------------------------
// mbr_chs_entry_encoder
// Builds the LBA, size and packed CHS fields of one MBR partition entry.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | word
// in_     | in  | in_valid/in_stall  | start_sector, end_sector
// out_    | out | out_valid/out_stall| lba, size, chs_valid, six CHS bytes
// cfg_    | in  | APB, pready high   | spt @0x0, hpc @0x4, cylinder count @0x8
//
// One word per cycle unless the output stalls: 32 cells divide by sectors per
// track, 32 more by heads per cylinder, then the output register.
// A stalled output word freezes the whole chain and stalls the input.
// Reset clears all valid bits and loads the default geometry (63/255/0).
// ----------------------------------------------------------------------------
module mbr_chs_entry_encoder
  import mce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [LBA_W-1:0]  in_start_sector,
  input  logic [LBA_W-1:0]  in_end_sector,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LBA_W-1:0]  out_lba_field,
  output logic [LBA_W-1:0]  out_size_field,
  output logic              out_chs_valid,
  output logic [7:0]        out_start_head_byte,
  output logic [7:0]        out_start_sector_byte,
  output logic [7:0]        out_start_cylinder_byte,
  output logic [7:0]        out_end_head_byte,
  output logic [7:0]        out_end_sector_byte,
  output logic [7:0]        out_end_cylinder_byte,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [SPT_W-1:0]    spt_r;
  logic [HPC_W-1:0]    hpc_r;
  logic [CYLCNT_W-1:0] cylcnt_r;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;
  logic                adv;
  logic                geo_ok;

  logic       a_vld [0:LBA_W];
  cell_data_t a_d   [0:LBA_W];
  logic       b_vld [0:LBA_W];
  cell_data_t b_d   [0:LBA_W];

  logic       out_valid_r;
  side_t      out_side_r;
  logic       out_chs_valid_r;
  chs_t       out_s_r;
  chs_t       out_e_r;
  chs_t       s_chs;
  chs_t       e_chs;

  // ---- configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r    <= SPT_RST;
      hpc_r    <= HPC_RST;
      cylcnt_r <= CYLCNT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SPT:    spt_r    <= cfg_pwdata[SPT_W-1:0];
        REG_HPC:    hpc_r    <= cfg_pwdata[HPC_W-1:0];
        REG_CYLCNT: cylcnt_r <= cfg_pwdata[CYLCNT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SPT:    cfg_prdata = {{(DATA_W-SPT_W){1'b0}}, spt_r};
      REG_HPC:    cfg_prdata = {{(DATA_W-HPC_W){1'b0}}, hpc_r};
      REG_CYLCNT: cfg_prdata = {{(DATA_W-CYLCNT_W){1'b0}}, cylcnt_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // ---- flow control: chain moves whenever the output register can take a word
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // ---- first chain: lba / sectors per track
  always_comb begin
    a_vld[0]            = in_valid;
    a_d[0].s.rem        = '0;
    a_d[0].s.work       = in_start_sector;
    a_d[0].e.rem        = '0;
    a_d[0].e.work       = in_end_sector - 32'd1;
    a_d[0].side.lba     = in_start_sector;
    a_d[0].side.size    = in_end_sector - in_start_sector;
    a_d[0].side.s_sec   = '0;
    a_d[0].side.e_sec   = '0;
  end

  // ---- second chain: track number / heads per cylinder
  always_comb begin
    b_vld[0]          = a_vld[LBA_W];
    b_d[0]            = a_d[LBA_W];
    b_d[0].s.rem      = '0;
    b_d[0].e.rem      = '0;
    b_d[0].side.s_sec = a_d[LBA_W].s.rem[SPT_W-1:0];
    b_d[0].side.e_sec = a_d[LBA_W].e.rem[SPT_W-1:0];
  end

  for (genvar i = 0; i < LBA_W; i++) begin : g_chain
    mce_div_cell u_a_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .divisor  ({{(DIV_W-SPT_W){1'b0}}, spt_r}),
      .vld_in   (a_vld[i]),
      .data_in  (a_d[i]),
      .vld_out  (a_vld[i+1]),
      .data_out (a_d[i+1])
    );

    mce_div_cell u_b_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .divisor  (hpc_r),
      .vld_in   (b_vld[i]),
      .data_in  (b_d[i]),
      .vld_out  (b_vld[i+1]),
      .data_out (b_d[i+1])
    );
  end

  // ---- CHS packing with cylinder saturation
  function automatic chs_t pack_chs(logic [LBA_W-1:0] cyl, logic [7:0] head,
                                    logic [SPT_W-1:0] sec, logic [SPT_W-1:0] spt,
                                    logic [HPC_W-1:0] hpc);
    logic [CYL_W-1:0] c;
    logic [7:0]       h;
    logic [SPT_W-1:0] s;
    logic [SPT_W-1:0] s1;
    chs_t             r;
    if (cyl > LBA_W'(MAX_CYLINDER)) begin
      c = CYL_W'(MAX_CYLINDER);
      h = hpc - 8'd1;
      s = spt - 6'd1;
    end else begin
      c = cyl[CYL_W-1:0];
      h = head;
      s = sec;
    end
    s1   = s + 6'd1;
    r.hb = h;
    r.sb = {c[9:8], s1};
    r.cb = c[7:0];
    return r;
  endfunction

  assign geo_ok = (spt_r != '0) && (hpc_r != '0) && (cylcnt_r != '0);
  assign s_chs  = pack_chs(b_d[LBA_W].s.work, b_d[LBA_W].s.rem,
                           b_d[LBA_W].side.s_sec, spt_r, hpc_r);
  assign e_chs  = pack_chs(b_d[LBA_W].e.work, b_d[LBA_W].e.rem,
                           b_d[LBA_W].side.e_sec, spt_r, hpc_r);

  // ---- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_vld[LBA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side_r      <= b_d[LBA_W].side;
      out_chs_valid_r <= geo_ok;
      out_s_r         <= geo_ok ? s_chs : '0;
      out_e_r         <= geo_ok ? e_chs : '0;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_lba_field           = out_side_r.lba;
  assign out_size_field          = out_side_r.size;
  assign out_chs_valid           = out_chs_valid_r;
  assign out_start_head_byte     = out_s_r.hb;
  assign out_start_sector_byte   = out_s_r.sb;
  assign out_start_cylinder_byte = out_s_r.cb;
  assign out_end_head_byte       = out_e_r.hb;
  assign out_end_sector_byte     = out_e_r.sb;
  assign out_end_cylinder_byte   = out_e_r.cb;

endmodule

### test/tb_mbr_chs_entry_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mbr_chs_entry_encoder
// Self-checking bench for the MBR CHS entry encoder. Extents go in through
// the valid/stall channel while the geometry registers are swept over the
// APB port between phases. Every output word is compared field by field
// against a local model of the LBA, size and CHS packing.
// ----------------------------------------------------------------------------
module tb_mbr_chs_entry_encoder;
  import mce_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         HANG_LIMIT = 2000;

  typedef struct packed {
    logic [LBA_W-1:0] lba;
    logic [LBA_W-1:0] size;
    logic             chs_ok;
    logic [7:0]       s_head;
    logic [7:0]       s_sec;
    logic [7:0]       s_cyl;
    logic [7:0]       e_head;
    logic [7:0]       e_sec;
    logic [7:0]       e_cyl;
  } entry_t;

  class extent_scoreboard;
    logic [SPT_W-1:0]    spt;
    logic [HPC_W-1:0]    hpc;
    logic [CYLCNT_W-1:0] cylcnt;
    entry_t              expected_q[$];
    int                  mismatches;

    function new();
      spt        = SPT_RST;
      hpc        = HPC_RST;
      cylcnt     = CYLCNT_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_SPT:    spt = val[SPT_W-1:0];
        REG_HPC:    hpc = val[HPC_W-1:0];
        REG_CYLCNT: cylcnt = val[CYLCNT_W-1:0];
        default:    ;
      endcase
    endfunction

    function chs_t encode_chs(logic [LBA_W-1:0] lba);
      logic [63:0] spt64;
      logic [63:0] hpc64;
      logic [63:0] sec;
      logic [63:0] head;
      logic [63:0] cyl;
      chs_t        r;
      spt64 = 64'(spt);
      hpc64 = 64'(hpc);
      sec   = 64'(lba) % spt64;
      head  = (64'(lba) / spt64) % hpc64;
      cyl   = 64'(lba) / (spt64 * hpc64);
      // past the last cylinder: pin to the last addressable sector
      if (cyl > 64'(MAX_CYLINDER)) begin
        cyl  = 64'(MAX_CYLINDER);
        head = hpc64 - 64'd1;
        sec  = spt64 - 64'd1;
      end
      sec  = sec + 64'd1;
      r.hb = head[7:0];
      r.sb = {cyl[9:8], sec[5:0]};
      r.cb = cyl[7:0];
      return r;
    endfunction

    function void note_extent(logic [LBA_W-1:0] s, logic [LBA_W-1:0] e);
      entry_t x;
      chs_t   t;
      x        = '0;
      x.lba    = s;
      x.size   = e - s;
      x.chs_ok = (spt != 0) && (hpc != 0) && (cylcnt != 0);
      if (x.chs_ok) begin
        t        = encode_chs(s);
        x.s_head = t.hb;
        x.s_sec  = t.sb;
        x.s_cyl  = t.cb;
        t        = encode_chs(e - 32'd1);
        x.e_head = t.hb;
        x.e_sec  = t.sb;
        x.e_cyl  = t.cb;
      end
      expected_q.push_back(x);
    endfunction

    function void flag(string what, logic [LBA_W-1:0] exp_v, logic [LBA_W-1:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", what, exp_v, act_v);
    endfunction

    function void check_entry(entry_t got);
      entry_t x;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: lba %0h size %0h", got.lba, got.size);
        return;
      end
      x = expected_q.pop_front();
      if (got.lba !== x.lba)       flag("lba", x.lba, got.lba);
      if (got.size !== x.size)     flag("size", x.size, got.size);
      if (got.chs_ok !== x.chs_ok) flag("chs_valid", 32'(x.chs_ok), 32'(got.chs_ok));
      if (got.s_head !== x.s_head) flag("start head", 32'(x.s_head), 32'(got.s_head));
      if (got.s_sec !== x.s_sec)   flag("start sector", 32'(x.s_sec), 32'(got.s_sec));
      if (got.s_cyl !== x.s_cyl)   flag("start cylinder", 32'(x.s_cyl), 32'(got.s_cyl));
      if (got.e_head !== x.e_head) flag("end head", 32'(x.e_head), 32'(got.e_head));
      if (got.e_sec !== x.e_sec)   flag("end sector", 32'(x.e_sec), 32'(got.e_sec));
      if (got.e_cyl !== x.e_cyl)   flag("end cylinder", 32'(x.e_cyl), 32'(got.e_cyl));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [LBA_W-1:0]  in_start_sector = '0;
  logic [LBA_W-1:0]  in_end_sector = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [LBA_W-1:0]  out_lba_field;
  logic [LBA_W-1:0]  out_size_field;
  logic              out_chs_valid;
  logic [7:0]        out_start_head_byte;
  logic [7:0]        out_start_sector_byte;
  logic [7:0]        out_start_cylinder_byte;
  logic [7:0]        out_end_head_byte;
  logic [7:0]        out_end_sector_byte;
  logic [7:0]        out_end_cylinder_byte;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  extent_scoreboard sb = new();
  bit               idling = 1'b1;
  int               stall_left = 0;
  int               hang_cycles = 0;

  mbr_chs_entry_encoder dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_start_sector         (in_start_sector),
    .in_end_sector           (in_end_sector),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_lba_field           (out_lba_field),
    .out_size_field          (out_size_field),
    .out_chs_valid           (out_chs_valid),
    .out_start_head_byte     (out_start_head_byte),
    .out_start_sector_byte   (out_start_sector_byte),
    .out_start_cylinder_byte (out_start_cylinder_byte),
    .out_end_head_byte       (out_end_head_byte),
    .out_end_sector_byte     (out_end_sector_byte),
    .out_end_cylinder_byte   (out_end_cylinder_byte),
    .cfg_psel                (cfg_psel),
    .cfg_penable             (cfg_penable),
    .cfg_pwrite              (cfg_pwrite),
    .cfg_paddr               (cfg_paddr),
    .cfg_pwdata              (cfg_pwdata),
    .cfg_prdata              (cfg_prdata),
    .cfg_pready              (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // output side: check accepted words, stall in short bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_entry({out_lba_field, out_size_field, out_chs_valid,
                      out_start_head_byte, out_start_sector_byte, out_start_cylinder_byte,
                      out_end_head_byte, out_end_sector_byte, out_end_cylinder_byte});
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= int'($urandom_range(0, 3));
    end else begin
      out_stall <= 1'b0;
    end
  end

  // hang detection: cycles in which no word and no register write moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
      if (hang_cycles == HANG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.write_reg(idx, val);
    // leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  // wait for the pipe to empty before touching the geometry
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // upper pwdata bits carry junk; the registers keep only their own width
  task automatic set_geometry(logic [SPT_W-1:0] s, logic [HPC_W-1:0] h,
                              logic [CYLCNT_W-1:0] c);
    logic [31:0] junk;
    settle();
    junk = $urandom;
    cfg_write(REG_SPT, {junk[31:SPT_W], s});
    junk = $urandom;
    cfg_write(REG_HPC, {junk[31:HPC_W], h});
    junk = $urandom;
    cfg_write(REG_CYLCNT, {junk[31:CYLCNT_W], c});
  endtask

  task automatic send_extent(logic [LBA_W-1:0] s, logic [LBA_W-1:0] e);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_start_sector <= s;
    in_end_sector   <= e;
    do @(posedge clk); while (in_stall);
    sb.note_extent(s, e);
  endtask

  task automatic send_random(int count);
    int unsigned span;
    logic [31:0] s;
    logic [31:0] e;
    span = 32'(sb.spt) * 32'(sb.hpc);
    if (span == 0) span = 16065;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          s = $urandom;
          e = $urandom;
        end
        3, 4, 5, 6: begin
          // mostly inside the addressable cylinders
          s = $urandom_range(0, span * 1100);
          e = s + $urandom_range(1, span * 3);
        end
        7: begin
          // straddle cylinder boundaries
          s = $urandom_range(0, 1030) * span + $urandom_range(0, 4) - 2;
          e = $urandom_range(0, 1030) * span + $urandom_range(0, 4) - 2;
        end
        8: begin
          s = $urandom;
          case ($urandom_range(0, 2))
            0:       e = 32'd0;
            1:       e = s;
            default: e = s - $urandom_range(1, 1000);
          endcase
        end
        default: begin
          s = $urandom;
          e = s + $urandom_range(0, 4);
        end
      endcase
      send_extent(s, e);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: cylinder count zero, CHS bytes stay clear
    send_extent(32'h0000_0000, 32'h0000_0000);
    send_extent(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_extent(32'h0000_0000, 32'hFFFF_FFFF);
    send_extent(32'hFFFF_FFFF, 32'h0000_0000);
    send_extent(32'h1234_5678, 32'h9ABC_DEF0);
    send_random(150);

    set_geometry(6'd63, 8'd255, 16'd1024);
    cfg_write(REG_UNUSED, $urandom);
    send_extent(32'd0, 32'd1);
    send_extent(32'd62, 32'd63);
    send_extent(32'd63, 32'd64);
    send_extent(32'd16064, 32'd16065);
    send_extent(32'd16065, 32'd16066);
    send_extent(32'd16450559, 32'd16450560);
    send_extent(32'd16450560, 32'd16450561);
    send_extent(32'd100, 32'd100);
    send_extent(32'd100, 32'd0);
    send_extent(32'd200, 32'd100);
    send_extent(32'hFFFF_FFFF, 32'h0000_0000);
    send_extent(32'h0000_0000, 32'hFFFF_FFFF);
    send_extent(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random(250);

    set_geometry(6'd1, 8'd1, 16'd1);
    send_extent(32'd1023, 32'd1024);
    send_extent(32'd1024, 32'd1025);
    send_extent(32'd0, 32'd0);
    send_random(200);

    set_geometry(6'd63, 8'd255, 16'd65535);
    send_random(200);

    set_geometry(6'd0, 8'd16, 16'd100);
    send_random(120);

    set_geometry(6'd16, 8'd0, 16'd100);
    send_random(120);

    repeat (4) begin
      set_geometry(SPT_W'($urandom_range(1, 63)), HPC_W'($urandom_range(1, 255)),
                   CYLCNT_W'($urandom_range(1, 65535)));
      send_random(180);
    end

    set_geometry(6'd2, 8'd3, 16'd7);
    idling = 1'b0;
    send_random(140);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
